### rtl/core/hba_pkg.sv
// Shared types and codes of the heap block allocator.
package hba_pkg;

  localparam int OFF_W  = 24;
  localparam int SIZE_W = 25;

  localparam logic [2:0] REQ_ALLOC_FIRST = 3'd0;
  localparam logic [2:0] REQ_ALLOC_BEST  = 3'd1;
  localparam logic [2:0] REQ_FREE        = 3'd2;
  localparam logic [2:0] REQ_REALLOC     = 3'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_ZERO   = 3'd1;
  localparam logic [2:0] ST_OOM    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_NOADDR = 3'd4;
  localparam logic [2:0] ST_UNSUP  = 3'd5;

  localparam logic [1:0] REG_HEAP_BASE    = 2'd0;
  localparam logic [1:0] REG_INITIAL_SIZE = 2'd1;
  localparam logic [1:0] REG_HEAP_LIMIT   = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [23:0] request_bytes;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [24:0] granted_bytes;
    logic [2:0]  status;
  } rsp_t;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
  } entry_t;

endpackage

### rtl/core/heap_block_allocator_core.sv
// Heap block allocator top level: request sequencer around the block table memory.
//
// Keeps an address-ordered table of heap blocks (offset, size with header, free mark)
// in one synchronous RAM of MAX_BLOCKS entries and serves one request at a time:
// first-fit or best-fit allocate, free with coalescing, and reallocate. Each table
// access goes through the single RAM read port with registered read data, so a
// request scans the table and moves entries one at a time when a block is
// inserted or removed, and rounds up to whole pages when the heap must grow; a
// moving reallocate frees and coalesces, scans again and splits. The table needs no
// clearing after reset: entries at or above the live count are never read, and
// writing initial_size rebuilds it as one free block. The result is held in an
// output register, so the next item is taken while the previous result still waits
// to be taken.
module heap_block_allocator_core #(
  parameter int MAX_BLOCKS     = 64,
  parameter int HEADER_BYTES   = 16,
  parameter int PAGE_BYTES     = 4096,
  parameter int MAX_HEAP_BYTES = 16777216
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hba_pkg::req_t in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output hba_pkg::rsp_t out_item,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  import hba_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int EW = $bits(entry_t);
  localparam int HARD_CAP = (MAX_HEAP_BYTES < 16777216) ? MAX_HEAP_BYTES : 16777216;
  localparam int RW = $clog2(PAGE_BYTES) + 1;

  localparam logic [CW-1:0]     MAXB = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0]     ONE  = CW'(1);
  localparam logic [SIZE_W-1:0] HDR  = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] CAP  = SIZE_W'(HARD_CAP);

  typedef enum logic [26:0] {
    S_IDLE    = 27'h0000001,
    S_DISP    = 27'h0000002,
    S_A_RD    = 27'h0000004,
    S_A_CHK   = 27'h0000008,
    S_A_END   = 27'h0000010,
    S_A_DIV   = 27'h0000020,
    S_A_GROW  = 27'h0000040,
    S_A_GROW2 = 27'h0000080,
    S_PLACE   = 27'h0000100,
    S_RES_OK  = 27'h0000200,
    S_F_RD    = 27'h0000400,
    S_F_CHK   = 27'h0000800,
    S_F_HIT   = 27'h0001000,
    S_G_CHK   = 27'h0002000,
    S_S_CHK   = 27'h0004000,
    S_S_WR2   = 27'h0008000,
    S_FR0     = 27'h0010000,
    S_FR1     = 27'h0020000,
    S_FR2     = 27'h0040000,
    S_FR3     = 27'h0080000,
    S_FR4     = 27'h0100000,
    S_FR_END  = 27'h0200000,
    S_INS_RD  = 27'h0400000,
    S_INS_WR  = 27'h0800000,
    S_REM_RD  = 27'h1000000,
    S_REM_WR  = 27'h2000000,
    S_DONE    = 27'h4000000
  } st_t;

  st_t st_r, st_nxt, ret_r, ret_nxt;

  logic              best_r, best_nxt;
  logic              aft_r, aft_nxt;
  logic              pick_r, pick_nxt;
  logic [2:0]        typ_r, typ_nxt;
  logic [23:0]       rq_r, rq_nxt;
  logic [31:0]       ad_r, ad_nxt;
  logic [SIZE_W-1:0] tot_r, tot_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cidx_r, cidx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     shk_r, shk_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  entry_t            cur_r, cur_nxt;
  entry_t            nb_r, nb_nxt;
  entry_t            ins_r, ins_nxt;
  logic [26:0]       grow_r, grow_nxt;
  logic [SIZE_W-1:0] hend_r, hend_nxt;
  logic [31:0]       base_r, base_nxt;
  logic [SIZE_W-1:0] lim_r, lim_nxt;
  rsp_t              res_r, res_nxt;
  rsp_t              out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_e;
  logic [EW-1:0] rd_raw;
  logic          div_start, div_done;
  logic [RW-1:0] div_rem;

  logic [SIZE_W-1:0] rem_sz, init_sz, cap;
  logic [25:0]       sum_sz;
  logic [26:0]       grow_rem, end_sum;
  logic [31:0]       pay_e, pay_cur;

  hba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_tab (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  hba_pgdiv #(.PAGE_BYTES(PAGE_BYTES)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tot_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign rd_e      = entry_t'(rd_raw);
  assign in_stall  = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  always_comb begin
    rem_sz   = cur_r.size - tot_r;
    sum_sz   = {1'b0, cur_r.size} + {1'b0, rd_e.size};
    grow_rem = grow_r - {2'b0, tot_r};
    end_sum  = {2'b0, hend_r} + grow_r;
    cap      = (lim_r < CAP) ? lim_r : CAP;
    init_sz  = (cfg_data[24:0] > CAP) ? CAP : cfg_data[24:0];
    pay_e    = base_r + 32'(rd_e.off) + 32'(HEADER_BYTES);
    pay_cur  = base_r + 32'(cur_r.off) + 32'(HEADER_BYTES);
  end

  always_comb begin
    st_nxt   = st_r;
    ret_nxt  = ret_r;
    best_nxt = best_r;
    aft_nxt  = aft_r;
    pick_nxt = pick_r;
    typ_nxt  = typ_r;
    rq_nxt   = rq_r;
    ad_nxt   = ad_r;
    tot_nxt  = tot_r;
    idx_nxt  = idx_r;
    cidx_nxt = cidx_r;
    pos_nxt  = pos_r;
    shk_nxt  = shk_r;
    cnt_nxt  = cnt_r;
    cur_nxt  = cur_r;
    nb_nxt   = nb_r;
    ins_nxt  = ins_r;
    grow_nxt = grow_r;
    hend_nxt = hend_r;
    base_nxt = base_r;
    lim_nxt  = lim_r;
    res_nxt  = res_r;
    out_nxt  = out_r;
    out_vld_nxt = out_vld_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_addr   = '0;
    div_start = 1'b0;

    // drop the result once it is taken
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end

    case (st_r)
      S_IDLE: begin
        if (cfg_valid) begin
          case (cfg_index)
            REG_HEAP_BASE: begin
              base_nxt = cfg_data;
            end
            REG_INITIAL_SIZE: begin
              // rebuild the table as one free block
              hend_nxt = init_sz;
              cnt_nxt  = (init_sz != '0) ? ONE : '0;
              wr_en    = 1'b1;
              wr_addr  = '0;
              wr_data  = '{free: 1'b1, size: init_sz, off: '0};
            end
            REG_HEAP_LIMIT: begin
              lim_nxt = cfg_data[24:0];
            end
            default: begin
            end
          endcase
        end
        if (in_valid) begin
          typ_nxt = in_item.req_type;
          rq_nxt  = in_item.request_bytes;
          ad_nxt  = in_item.block_address;
          tot_nxt = SIZE_W'(in_item.request_bytes) + HDR;
          st_nxt  = S_DISP;
        end
      end

      S_DISP: begin
        idx_nxt  = '0;
        pick_nxt = 1'b0;
        best_nxt = (typ_r == REQ_ALLOC_BEST);
        if (typ_r == REQ_ALLOC_FIRST || typ_r == REQ_ALLOC_BEST ||
            (typ_r == REQ_REALLOC && ad_r == '0)) begin
          if (rq_r == '0) begin
            res_nxt = '{result_address: '0, granted_bytes: '0, status: ST_ZERO};
            st_nxt  = S_DONE;
          end else begin
            st_nxt = S_A_RD;
          end
        end else if (typ_r == REQ_FREE || typ_r == REQ_REALLOC) begin
          if (ad_r == '0) begin
            res_nxt = '{result_address: '0, granted_bytes: '0, status: ST_ZERO};
            st_nxt  = S_DONE;
          end else begin
            st_nxt = S_F_RD;
          end
        end else begin
          res_nxt = '{result_address: '0, granted_bytes: '0, status: ST_UNSUP};
          st_nxt  = S_DONE;
        end
      end

      // fit scan
      S_A_RD: begin
        rd_addr = idx_r[AW-1:0];
        st_nxt  = (idx_r < cnt_r) ? S_A_CHK : S_A_END;
      end

      S_A_CHK: begin
        st_nxt  = S_A_RD;
        idx_nxt = idx_r + ONE;
        if (rd_e.free && rd_e.size >= tot_r) begin
          if (!pick_r || rd_e.size < cur_r.size) begin
            pick_nxt = 1'b1;
            cur_nxt  = rd_e;
            cidx_nxt = idx_r;
          end
          if (!best_r) begin
            st_nxt = S_A_END;
          end
        end
      end

      S_A_END: begin
        if (pick_r) begin
          st_nxt = S_PLACE;
        end else if (cnt_r >= MAXB) begin
          res_nxt = '{result_address: '0, granted_bytes: '0, status: ST_FULL};
          st_nxt  = S_DONE;
        end else begin
          div_start = 1'b1;
          st_nxt    = S_A_DIV;
        end
      end

      S_A_DIV: begin
        if (div_done) begin
          // round the total up to whole pages
          grow_nxt = {2'b0, tot_r} +
                     ((div_rem == '0) ? 27'd0 : 27'(PAGE_BYTES) - 27'(div_rem));
          st_nxt   = S_A_GROW;
        end
      end

      S_A_GROW: begin
        if (end_sum > {2'b0, cap}) begin
          res_nxt = '{result_address: '0, granted_bytes: '0, status: ST_OOM};
          st_nxt  = S_DONE;
        end else begin
          cidx_nxt = cnt_r;
          cur_nxt.free = 1'b0;
          cur_nxt.off  = hend_r[OFF_W-1:0];
          wr_en   = 1'b1;
          wr_addr = cnt_r[AW-1:0];
          hend_nxt = end_sum[SIZE_W-1:0];
          cnt_nxt  = cnt_r + ONE;
          if (grow_rem >= {2'b0, HDR} && (cnt_r + ONE) < MAXB) begin
            cur_nxt.size = tot_r;
            st_nxt       = S_A_GROW2;
          end else begin
            cur_nxt.size = grow_r[SIZE_W-1:0];
            st_nxt       = S_RES_OK;
          end
          wr_data = cur_nxt;
        end
      end

      S_A_GROW2: begin
        // page remainder becomes a free block behind the new one
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        wr_data = '{free: 1'b1, size: grow_rem[SIZE_W-1:0],
                    off: cur_r.off + tot_r[OFF_W-1:0]};
        cnt_nxt = cnt_r + ONE;
        st_nxt  = S_RES_OK;
      end

      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = cidx_r[AW-1:0];
        cur_nxt.free = 1'b0;
        if (rem_sz > HDR && cnt_r < MAXB) begin
          cur_nxt.size = tot_r;
          ins_nxt = '{free: 1'b1, size: rem_sz, off: cur_r.off + tot_r[OFF_W-1:0]};
          pos_nxt = cidx_r + ONE;
          shk_nxt = cnt_r;
          ret_nxt = S_RES_OK;
          st_nxt  = S_INS_RD;
        end else begin
          st_nxt = S_RES_OK;
        end
        wr_data = cur_nxt;
      end

      S_RES_OK: begin
        res_nxt = '{result_address: pay_cur, granted_bytes: cur_r.size, status: ST_OK};
        st_nxt  = S_DONE;
      end

      // address lookup
      S_F_RD: begin
        rd_addr = idx_r[AW-1:0];
        if (idx_r < cnt_r) begin
          st_nxt = S_F_CHK;
        end else begin
          res_nxt = '{result_address: '0, granted_bytes: '0, status: ST_NOADDR};
          st_nxt  = S_DONE;
        end
      end

      S_F_CHK: begin
        if (!rd_e.free && pay_e == ad_r) begin
          cur_nxt  = rd_e;
          cidx_nxt = idx_r;
          st_nxt   = S_F_HIT;
        end else begin
          idx_nxt = idx_r + ONE;
          st_nxt  = S_F_RD;
        end
      end

      S_F_HIT: begin
        rd_addr = AW'(cidx_r + ONE);
        aft_nxt = 1'b0;
        if (typ_r == REQ_FREE || rq_r == '0) begin
          st_nxt = S_FR0;
        end else if (tot_r > cur_r.size) begin
          aft_nxt = 1'b1;
          st_nxt  = ((cidx_r + ONE) < cnt_r) ? S_G_CHK : S_FR0;
        end else if (tot_r < cur_r.size) begin
          st_nxt = ((cidx_r + ONE) < cnt_r) ? S_S_CHK : S_PLACE;
        end else begin
          st_nxt = S_RES_OK;
        end
      end

      S_G_CHK: begin
        // grow in place into a free next block
        if (rd_e.free && sum_sz >= {1'b0, tot_r}) begin
          cur_nxt.size = sum_sz[SIZE_W-1:0];
          aft_nxt = 1'b0;
          shk_nxt = cidx_r + ONE;
          ret_nxt = S_PLACE;
          st_nxt  = S_REM_RD;
        end else begin
          st_nxt = S_FR0;
        end
      end

      S_S_CHK: begin
        if (rd_e.free) begin
          // hand the shrink remainder to the free next block
          cur_nxt.size = tot_r;
          wr_en   = 1'b1;
          wr_addr = cidx_r[AW-1:0];
          wr_data = cur_nxt;
          nb_nxt  = '{free: 1'b1, size: rd_e.size + rem_sz,
                      off: rd_e.off - rem_sz[OFF_W-1:0]};
          st_nxt  = S_S_WR2;
        end else begin
          st_nxt = S_PLACE;
        end
      end

      S_S_WR2: begin
        wr_en   = 1'b1;
        wr_addr = AW'(cidx_r + ONE);
        wr_data = nb_r;
        st_nxt  = S_RES_OK;
      end

      // free with coalescing
      S_FR0: begin
        rd_addr = AW'(cidx_r + ONE);
        st_nxt  = ((cidx_r + ONE) < cnt_r) ? S_FR1 : S_FR2;
      end

      S_FR1: begin
        if (rd_e.free) begin
          cur_nxt.size = sum_sz[SIZE_W-1:0];
          cur_nxt.free = 1'b1;
          wr_en   = 1'b1;
          wr_addr = cidx_r[AW-1:0];
          wr_data = cur_nxt;
          shk_nxt = cidx_r + ONE;
          ret_nxt = S_FR3;
          st_nxt  = S_REM_RD;
        end else begin
          st_nxt = S_FR2;
        end
      end

      S_FR2: begin
        cur_nxt.free = 1'b1;
        wr_en   = 1'b1;
        wr_addr = cidx_r[AW-1:0];
        wr_data = cur_nxt;
        st_nxt  = S_FR3;
      end

      S_FR3: begin
        rd_addr = AW'(cidx_r - ONE);
        st_nxt  = (cidx_r != '0) ? S_FR4 : S_FR_END;
      end

      S_FR4: begin
        if (rd_e.free) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cidx_r - ONE);
          wr_data = '{free: 1'b1, size: rd_e.size + cur_r.size, off: rd_e.off};
          shk_nxt = cidx_r;
          ret_nxt = S_FR_END;
          st_nxt  = S_REM_RD;
        end else begin
          st_nxt = S_FR_END;
        end
      end

      S_FR_END: begin
        if (aft_r) begin
          // moving reallocate: first-fit allocation after the release
          best_nxt = 1'b0;
          pick_nxt = 1'b0;
          idx_nxt  = '0;
          st_nxt   = S_A_RD;
        end else begin
          res_nxt = '{result_address: '0, granted_bytes: '0, status: ST_ZERO};
          st_nxt  = S_DONE;
        end
      end

      // insert ins_r at pos_r, moving entries up one place
      S_INS_RD: begin
        rd_addr = AW'(shk_r - ONE);
        if (shk_r > pos_r) begin
          st_nxt = S_INS_WR;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos_r[AW-1:0];
          wr_data = ins_r;
          cnt_nxt = cnt_r + ONE;
          st_nxt  = ret_r;
        end
      end

      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = shk_r[AW-1:0];
        wr_data = rd_e;
        shk_nxt = shk_r - ONE;
        st_nxt  = S_INS_RD;
      end

      // remove the entry at shk_r, moving entries down one place
      S_REM_RD: begin
        rd_addr = AW'(shk_r + ONE);
        if ((shk_r + ONE) < cnt_r) begin
          st_nxt = S_REM_WR;
        end else begin
          cnt_nxt = cnt_r - ONE;
          st_nxt  = ret_r;
        end
      end

      S_REM_WR: begin
        wr_en   = 1'b1;
        wr_addr = shk_r[AW-1:0];
        wr_data = rd_e;
        shk_nxt = shk_r + ONE;
        st_nxt  = S_REM_RD;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_vld_r || !out_stall) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          st_nxt      = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ret_r     <= S_IDLE;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      hend_r    <= '0;
      base_r    <= '0;
      lim_r     <= SIZE_W'(16777216);
      pick_r    <= 1'b0;
      best_r    <= 1'b0;
      aft_r     <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      ret_r     <= ret_nxt;
      out_vld_r <= out_vld_nxt;
      cnt_r     <= cnt_nxt;
      hend_r    <= hend_nxt;
      base_r    <= base_nxt;
      lim_r     <= lim_nxt;
      pick_r    <= pick_nxt;
      best_r    <= best_nxt;
      aft_r     <= aft_nxt;
    end
    typ_r  <= typ_nxt;
    rq_r   <= rq_nxt;
    ad_r   <= ad_nxt;
    tot_r  <= tot_nxt;
    idx_r  <= idx_nxt;
    cidx_r <= cidx_nxt;
    pos_r  <= pos_nxt;
    shk_r  <= shk_nxt;
    cur_r  <= cur_nxt;
    nb_r   <= nb_nxt;
    ins_r  <= ins_nxt;
    grow_r <= grow_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule

### rtl/core/hba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/hba_pgdiv.sv
// Page remainder unit: byte count modulo the page size by reciprocal multiplication.
module hba_pgdiv #(
  parameter int PAGE_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [24:0]                     dividend,
  output logic                            done,
  output logic [$clog2(PAGE_BYTES):0]     rem
);

  localparam int RW = $clog2(PAGE_BYTES) + 1;
  localparam int LW = $clog2(PAGE_BYTES);
  localparam int SH = 25 + LW;

  // floor(2^SH / page): the quotient estimate is exact or one short
  localparam longint unsigned RECIP_L = (64'd1 << SH) / 64'(PAGE_BYTES);
  localparam logic [25:0]     RECIP   = 26'(RECIP_L);
  localparam logic [16:0]     PG      = 17'(PAGE_BYTES);
  localparam logic [RW-1:0]   PG_R    = RW'(PAGE_BYTES);

  logic          v1_r, v2_r, v3_r, done_r;
  logic [24:0]   x_r;
  logic [50:0]   prod_r;
  logic [41:0]   qp_r;
  logic [RW-1:0] r_r;

  logic [24:0]   quo;
  logic [41:0]   diff;
  logic [RW-1:0] r_raw;

  always_comb begin
    quo   = 25'(prod_r >> SH);
    diff  = {17'b0, x_r} - qp_r;
    r_raw = diff[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
    if (start) begin
      x_r <= dividend;
    end
    prod_r <= {26'b0, x_r} * {25'b0, RECIP};
    qp_r   <= {17'b0, quo} * {25'b0, PG};
    // fold the estimate that fell one page short
    r_r    <= (r_raw >= PG_R) ? r_raw - PG_R : r_raw;
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

### tb/tb_top.sv
// Self-checking testbench for heap_block_allocator_core: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
  import hba_pkg::*;

  localparam int NBLK     = 64;
  localparam int HDR      = 16;
  localparam int PAGE     = 4096;
  localparam longint unsigned CAP = 64'd16777216; // min of MAX_HEAP_BYTES and 2^24
  localparam int WDOG_MAX = 20000;
  localparam int SETTLE   = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  req_t       in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rsp_t       out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_HEAP_BASE;
  logic [31:0] cfg_data = '0;

  heap_block_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block table and configuration.
  longint unsigned blk_off [NBLK];
  longint unsigned blk_size[NBLK];
  bit              blk_free[NBLK];
  int              blk_cnt;
  longint unsigned heap_top;
  longint unsigned base_addr;
  longint unsigned grow_limit;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   pushed_cnt, accepted_cnt, checked_cnt, errors;
  int   status_seen[8];
  int   send_idle_pct, recv_stall_pct;
  int   quiet_cycles;

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    errors++;
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", checked_cnt, field, got, want);
  endtask

  function automatic longint unsigned payload_addr(int i);
    return (base_addr + blk_off[i] + HDR) & 64'hFFFF_FFFF;
  endfunction

  function automatic void tbl_insert(int pos, longint unsigned off, longint unsigned sz, bit fr);
    for (int k = blk_cnt; k > pos; k--) begin
      blk_off[k] = blk_off[k-1];
      blk_size[k] = blk_size[k-1];
      blk_free[k] = blk_free[k-1];
    end
    blk_off[pos] = off & 64'hFF_FFFF;
    blk_size[pos] = sz & 64'h1FF_FFFF;
    blk_free[pos] = fr;
    blk_cnt++;
  endfunction

  function automatic void tbl_remove(int pos);
    for (int k = pos; k + 1 < blk_cnt; k++) begin
      blk_off[k] = blk_off[k+1];
      blk_size[k] = blk_size[k+1];
      blk_free[k] = blk_free[k+1];
    end
    blk_cnt--;
  endfunction

  // Mark allocated, splitting off a free tail when it is larger than a header and the table has room.
  function automatic void claim_block(int i, longint unsigned total);
    longint unsigned rem;
    rem = blk_size[i] - total;
    blk_free[i] = 1'b0;
    if (rem > HDR && blk_cnt < NBLK) begin
      blk_size[i] = total;
      tbl_insert(i + 1, blk_off[i] + total, rem, 1'b1);
    end
  endfunction

  function automatic void release_block(int i);
    blk_free[i] = 1'b1;
    if (i + 1 < blk_cnt && blk_free[i+1]) begin
      blk_size[i] += blk_size[i+1];
      tbl_remove(i + 1);
    end
    if (i > 0 && blk_free[i-1]) begin
      blk_size[i-1] += blk_size[i];
      tbl_remove(i);
    end
  endfunction

  function automatic rsp_t make_rsp(longint unsigned a, longint unsigned sz, logic [2:0] st);
    rsp_t r;
    r.result_address = a[31:0];
    r.granted_bytes = sz[24:0];
    r.status = st;
    return r;
  endfunction

  function automatic rsp_t heap_alloc(bit best, longint unsigned nbytes);
    longint unsigned total, grow, rem, cap;
    int pick, n;
    total = nbytes + HDR;
    pick = -1;
    if (nbytes == 0) return make_rsp(0, 0, ST_ZERO);
    for (int i = 0; i < blk_cnt; i++) begin
      if (!blk_free[i] || blk_size[i] < total) continue;
      if (pick < 0) begin
        pick = i;
        if (!best) break;
      end else if (blk_size[i] < blk_size[pick]) begin
        pick = i;
      end
    end
    if (pick >= 0) begin
      claim_block(pick, total);
      return make_rsp(payload_addr(pick), blk_size[pick], ST_OK);
    end
    if (blk_cnt >= NBLK) return make_rsp(0, 0, ST_FULL);
    grow = ((total + PAGE - 1) / PAGE) * PAGE;
    cap = (grow_limit < CAP) ? grow_limit : CAP;
    if (heap_top + grow > cap) return make_rsp(0, 0, ST_OOM);
    n = blk_cnt;
    tbl_insert(n, heap_top, total, 1'b0);
    rem = grow - total;
    if (rem >= HDR && blk_cnt < NBLK) tbl_insert(n + 1, heap_top + total, rem, 1'b1);
    else blk_size[n] = total + rem;
    heap_top += grow;
    return make_rsp(payload_addr(n), blk_size[n], ST_OK);
  endfunction

  function automatic rsp_t serve_request(req_t r);
    longint unsigned nbytes, total, rem;
    int f;
    nbytes = r.request_bytes;
    total = nbytes + HDR;
    f = -1;
    if (r.req_type == REQ_ALLOC_FIRST || r.req_type == REQ_ALLOC_BEST)
      return heap_alloc(r.req_type == REQ_ALLOC_BEST, nbytes);
    if (r.req_type != REQ_FREE && r.req_type != REQ_REALLOC) return make_rsp(0, 0, ST_UNSUP);
    if (r.block_address == 0) begin
      if (r.req_type == REQ_FREE) return make_rsp(0, 0, ST_ZERO);
      return heap_alloc(1'b0, nbytes);
    end
    for (int i = 0; i < blk_cnt; i++)
      if (!blk_free[i] && payload_addr(i) == r.block_address) begin
        f = i;
        break;
      end
    if (f < 0) return make_rsp(0, 0, ST_NOADDR);
    if (r.req_type == REQ_FREE || nbytes == 0) begin
      release_block(f);
      return make_rsp(0, 0, ST_ZERO);
    end
    if (total > blk_size[f]) begin
      if (f + 1 < blk_cnt && blk_free[f+1] && blk_size[f] + blk_size[f+1] >= total) begin
        blk_size[f] += blk_size[f+1];
        tbl_remove(f + 1);
        claim_block(f, total);
        return make_rsp(payload_addr(f), blk_size[f], ST_OK);
      end
      release_block(f);
      return heap_alloc(1'b0, nbytes);
    end
    if (total < blk_size[f]) begin
      rem = blk_size[f] - total;
      if (f + 1 < blk_cnt && blk_free[f+1]) begin
        blk_size[f] = total;
        blk_off[f+1] = (blk_off[f+1] - rem) & 64'hFF_FFFF;
        blk_size[f+1] = (blk_size[f+1] + rem) & 64'h1FF_FFFF;
      end else begin
        claim_block(f, total);
      end
    end
    return make_rsp(payload_addr(f), blk_size[f], ST_OK);
  endfunction

  function automatic void apply_config(logic [1:0] idx, logic [31:0] value);
    longint unsigned v;
    v = value;
    if (idx == REG_HEAP_BASE) begin
      base_addr = v;
    end else if (idx == REG_INITIAL_SIZE) begin
      v = v & 64'h1FF_FFFF;
      if (v > CAP) v = CAP;
      heap_top = v;
      blk_cnt = 0;
      if (v != 0) tbl_insert(0, 0, v, 1'b1);
    end else if (idx == REG_HEAP_LIMIT) begin
      grow_limit = v & 64'h1FF_FFFF;
    end
  endfunction

  // Driver: take the next item from the pending queue, hold it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rsps.push_back(serve_request(in_item));
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest expectation, then pick the stall.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_item), 64'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_item.result_address !== want.result_address)
            report_mismatch("result_address", out_item.result_address, want.result_address);
          if (out_item.granted_bytes !== want.granted_bytes)
            report_mismatch("granted_bytes", out_item.granted_bytes, want.granted_bytes);
          if (out_item.status !== want.status)
            report_mismatch("status", out_item.status, want.status);
          status_seen[want.status]++;
        end
        checked_cnt++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || expected_rsps.size() != 0) @(posedge clk);
  endtask

  // Write one register while idle; the predictor follows at the handshake.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_config(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_heap(logic [31:0] b, logic [31:0] init, logic [31:0] lim);
    write_reg(REG_HEAP_BASE, b);
    write_reg(REG_HEAP_LIMIT, lim);
    write_reg(REG_INITIAL_SIZE, init);
  endtask

  // Queue one item; the lag bound keeps table lookups close to the accepted state.
  task automatic push_req(logic [2:0] kind, logic [23:0] nbytes, logic [31:0] addr, int lag);
    req_t r;
    while (pushed_cnt - accepted_cnt > lag) @(posedge clk);
    r.req_type = kind;
    r.request_bytes = nbytes;
    r.block_address = addr;
    pending_reqs.push_back(r);
    pushed_cnt++;
  endtask

  function automatic int pick_allocated();
    int idx[$];
    for (int i = 0; i < blk_cnt; i++) if (!blk_free[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(idx.size() - 1)];
  endfunction

  function automatic logic [23:0] pick_size();
    case ($urandom_range(11))
      0: return 24'($urandom);
      1: return 24'($urandom_range(3000, 9000));
      2: return 24'hFFFFFF;
      default: return 24'($urandom_range(1, 400));
    endcase
  endfunction

  task automatic random_req(int alloc_pct);
    int sel, k;
    logic [31:0] live;
    logic [23:0] sz;
    sel = $urandom_range(99);
    k = pick_allocated();
    live = (k < 0) ? $urandom : 32'(payload_addr(k));
    if (sel < alloc_pct) begin
      push_req($urandom_range(1) ? REQ_ALLOC_BEST : REQ_ALLOC_FIRST, pick_size(), $urandom, 1);
    end else if (sel < alloc_pct + (100 - alloc_pct) * 2 / 5) begin
      push_req(REQ_FREE, 24'($urandom), live, 1);
    end else if (sel < alloc_pct + (100 - alloc_pct) * 4 / 5) begin
      case ($urandom_range(5))
        0: sz = 0;
        1: sz = (k < 0) ? 24'd8 : 24'(blk_size[k] - HDR); // same size
        default: sz = pick_size();
      endcase
      push_req(REQ_REALLOC, sz, live, 1);
    end else begin
      // Noise: unsupported codes, null and bogus addresses, zero sizes.
      case ($urandom_range(5))
        0: push_req(3'($urandom_range(4, 7)), 24'($urandom), $urandom, 1);
        1: push_req($urandom_range(1) ? REQ_FREE : REQ_REALLOC, 24'($urandom), $urandom, 1);
        2: push_req(REQ_FREE, 24'($urandom), 32'd0, 1);
        3: push_req($urandom_range(1) ? REQ_ALLOC_BEST : REQ_ALLOC_FIRST, 24'd0, $urandom, 1);
        4: push_req(REQ_REALLOC, pick_size(), 32'd0, 1);
        default: push_req(REQ_FREE, 24'($urandom), live + 32'd1, 1);
      endcase
    end
  endtask

  task automatic random_phase(int n, int sidle, int rstall, int alloc_pct);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++) random_req(alloc_pct);
  endtask

  task automatic directed_live(logic [2:0] kind, int delta, bit zero);
    int k;
    logic [23:0] sz;
    wait_drained();
    k = pick_allocated();
    sz = (k < 0) ? 24'd32 : 24'(blk_size[k] - HDR + delta);
    if (zero) sz = 0;
    push_req(kind, sz, (k < 0) ? 32'd0 : 32'(payload_addr(k)), 0);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    base_addr = 0;
    grow_limit = 64'd16777216;
    heap_top = 0;
    blk_cnt = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every request code, the null and unknown address cases.
    setup_heap(32'h0000_1000, 32'd8192, 32'h01FF_FFFF);
    push_req(REQ_ALLOC_FIRST, 24'd0, 32'd0, 0);
    push_req(REQ_ALLOC_FIRST, 24'd1, 32'd0, 0);
    push_req(REQ_ALLOC_BEST, 24'hFFFFFF, 32'hFFFF_FFFF, 0);
    push_req(REQ_ALLOC_FIRST, 24'd100, 32'd0, 0);
    push_req(REQ_ALLOC_BEST, 24'd40, 32'd0, 0);
    push_req(REQ_ALLOC_FIRST, 24'd9000, 32'd0, 0);
    push_req(REQ_FREE, 24'hFFFFFF, 32'd0, 0);
    push_req(REQ_FREE, 24'd0, 32'hFFFF_FFFF, 0);
    for (int t = 4; t < 8; t++) push_req(3'(t), 24'hFFFFFF, 32'hFFFF_FFFF, 0);
    push_req(REQ_REALLOC, 24'd64, 32'd0, 0);
    directed_live(REQ_REALLOC, 50, 1'b0);
    directed_live(REQ_REALLOC, -20, 1'b0);
    directed_live(REQ_REALLOC, 0, 1'b0);
    directed_live(REQ_REALLOC, 5000, 1'b0);
    directed_live(REQ_REALLOC, 0, 1'b1);
    directed_live(REQ_FREE, 0, 1'b0);
    directed_live(REQ_FREE, 0, 1'b0);
    push_req(REQ_ALLOC_BEST, 24'd8000, 32'd0, 0);

    // Empty heap that must grow by pages, table filling under allocation pressure.
    setup_heap(32'd0, 32'd0, 32'd16777216);
    random_phase(130, 0, 0, 70);
    // Base that wraps the address space, oversized initial heap, no growth allowed.
    setup_heap(32'hFFFF_FFF0, 32'h01FF_FFFF, 32'd0);
    random_phase(130, 72, 0, 50);
    setup_heap($urandom, 32'd4096, 32'd8192);
    random_phase(130, 0, 72, 50);
    setup_heap($urandom, 32'd100, 32'd65536);
    random_phase(70, 9, 9, 65);
    // Hold off the sender until every result is back, then continue.
    wait_drained();
    random_phase(70, 9, 9, 40);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests in five heap setups, %0d results checked", accepted_cnt,
             checked_cnt);
    $display("Status mix: ok %0d zero/freed %0d oom %0d full %0d noaddr %0d unsup %0d",
             status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_OOM],
             status_seen[ST_FULL], status_seen[ST_NOADDR], status_seen[ST_UNSUP]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
